// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker modules
// Each macro wraps one clocked concurrent assertion, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge
`define OWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge
`define OWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Types and constants of the 1-Wire bus master timing engine.
// ----------------------------------------------------------------------------
package owm_pkg;

  // Bits in one byte transfer
  localparam int BITS_PER_BYTE = 8;
  localparam int TICK_W        = 10;
  localparam int BIT_IDX_W     = 3;
  localparam int CFG_IDX_W     = 3;

  // Command opcodes
  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RST_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_SAMPLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RST_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WR_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WR_SLOT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RD_LOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RD_SAMPLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RD_REC      = 3'd7;

  // Register values after reset
  localparam logic [TICK_W-1:0] RST_LOW_DEF     = 10'd500;
  localparam logic [TICK_W-1:0] PRES_SAMPLE_DEF = 10'd30;
  localparam logic [TICK_W-1:0] RST_TAIL_DEF    = 10'd470;
  localparam logic [TICK_W-1:0] WR_LOW_DEF      = 10'd5;
  localparam logic [TICK_W-1:0] WR_SLOT_DEF     = 10'd80;
  localparam logic [TICK_W-1:0] RD_LOW_DEF      = 10'd2;
  localparam logic [TICK_W-1:0] RD_SAMPLE_DEF   = 10'd15;
  localparam logic [TICK_W-1:0] RD_REC_DEF      = 10'd15;

  // Bus phase, one-hot
  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_TAIL = 10'b00_0000_1000,
    PH_WR_LOW   = 10'b00_0001_0000,
    PH_WR_SLOT  = 10'b00_0010_0000,
    PH_WR_GAP   = 10'b00_0100_0000,
    PH_RD_LOW   = 10'b00_1000_0000,
    PH_RD_WAIT  = 10'b01_0000_0000,
    PH_RD_REC   = 10'b10_0000_0000
  } phase_t;

  // Outcome of closing one phase
  typedef struct packed {
    phase_t               next_ph;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic [7:0]           shift;
    logic                 rd_load;
    logic                 pres_load;
    logic                 pres_val;
  } fin_t;

endpackage

// ===== rtl/one_wire_bus_master_core.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// 1-Wire bus master timing engine: reset/presence, byte write and byte read.
// ----------------------------------------------------------------------------
// Every input transaction is one microsecond tick carrying the sampled bus
// level and an optional command. The tick is processed in the cycle it is
// accepted and its result (line drive, busy, done, last read byte, presence)
// appears in the output register on the next cycle, so one tick is taken per
// clock unless input is held off. The only thing that holds off input is a
// full output register whose result is stalled. Slot timing is set by the
// configuration registers (in ticks); the user must write them only while no
// command runs, as the block itself does not enforce it. Bytes go out and
// come in LSB first; a write byte ends with BYTE_GAP_TICKS released ticks.
module one_wire_bus_master_core #(
  parameter int unsigned BYTE_GAP_TICKS = 100
) (
  input  logic       clk,
  input  logic       rst_n,
  // tick input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd_valid,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_write_data,
  input  logic       in_line_level,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_line_release,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_data,
  output logic       out_presence,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::TICK_W-1:0]    cfg_data
);

  import owm_pkg::*;

  localparam logic [TICK_W-1:0]    GAP_LEN  = TICK_W'(BYTE_GAP_TICKS);
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

  // Configuration registers
  logic [TICK_W-1:0] rst_low_r, pres_sample_r, rst_tail_r, wr_low_r;
  logic [TICK_W-1:0] wr_slot_r, rd_low_r, rd_sample_r, rd_rec_r;

  // Engine state
  phase_t               phase_r, phase_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [7:0]           rd_byte_r, rd_byte_nxt;
  logic                 pres_r, pres_nxt;

  // Output register
  logic       out_valid_r;
  logic       release_r, busy_r, done_r;
  logic       release_nxt, busy_nxt, done_nxt;

  logic       in_accept;
  logic       start;
  phase_t     ph0;
  logic [TICK_W-1:0]    tc0, tc1;
  logic [BIT_IDX_W-1:0] bi0;
  logic [7:0]           sb0;
  fin_t       fin1, fin2;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  // Length of a phase in ticks; tail, recovery and gap may be zero
  function automatic logic [TICK_W-1:0] phase_len(input phase_t ph);
    logic [TICK_W-1:0] len;
    case (ph)
      PH_RST_LOW:  len = at_least_one(rst_low_r);
      PH_RST_WAIT: len = at_least_one(pres_sample_r);
      PH_RST_TAIL: len = rst_tail_r;
      PH_WR_LOW:   len = at_least_one(wr_low_r);
      PH_WR_SLOT:  len = at_least_one(wr_slot_r);
      PH_WR_GAP:   len = GAP_LEN;
      PH_RD_LOW:   len = at_least_one(rd_low_r);
      PH_RD_WAIT:  len = at_least_one(rd_sample_r);
      PH_RD_REC:   len = rd_rec_r;
      default:     len = TICK_W'(1);
    endcase
    return len;
  endfunction

  // Close a phase: sample, shift and pick the following phase
  function automatic fin_t finish(input phase_t ph, input logic line,
                                  input logic [BIT_IDX_W-1:0] bi,
                                  input logic [7:0] sb);
    fin_t f;
    f.next_ph   = PH_IDLE;
    f.bit_idx   = bi;
    f.shift     = sb;
    f.rd_load   = 1'b0;
    f.pres_load = 1'b0;
    f.pres_val  = ~line;
    case (ph)
      PH_RST_LOW:  f.next_ph = PH_RST_WAIT;
      PH_RST_WAIT: begin
        f.pres_load = 1'b1;
        f.next_ph   = PH_RST_TAIL;
      end
      PH_WR_LOW:   f.next_ph = PH_WR_SLOT;
      PH_WR_SLOT:  begin
        f.shift = {1'b0, sb[7:1]};
        if (bi == LAST_BIT) begin
          f.bit_idx = '0;
          f.next_ph = PH_WR_GAP;
        end else begin
          f.bit_idx = bi + 1'b1;
          f.next_ph = PH_WR_LOW;
        end
      end
      PH_RD_LOW:   f.next_ph = PH_RD_WAIT;
      PH_RD_WAIT:  begin
        f.shift   = {line, sb[7:1]};
        f.next_ph = PH_RD_REC;
      end
      PH_RD_REC:   begin
        if (bi == LAST_BIT) begin
          f.bit_idx = '0;
          f.rd_load = 1'b1;
          f.next_ph = PH_IDLE;
        end else begin
          f.bit_idx = bi + 1'b1;
          f.next_ph = PH_RD_LOW;
        end
      end
      default:     f.next_ph = PH_IDLE;
    endcase
    return f;
  endfunction

  // Handshakes: hold input only while a result is stalled in the output
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Command start, then this tick's phase context
  assign start = (phase_r == PH_IDLE) & in_cmd_valid & (in_opcode != OP_NONE);

  always_comb begin
    ph0 = phase_r;
    tc0 = tick_r;
    bi0 = bit_r;
    sb0 = shift_r;
    if (start) begin
      tc0 = '0;
      bi0 = '0;
      sb0 = '0;
      case (in_opcode)
        OP_RESET: ph0 = PH_RST_LOW;
        OP_WRITE: begin
          ph0 = PH_WR_LOW;
          sb0 = in_write_data;
        end
        OP_READ:  ph0 = PH_RD_LOW;
        default:  ph0 = PH_IDLE;
      endcase
    end
  end

  assign tc1  = tc0 + 1'b1;
  assign fin1 = finish(ph0, in_line_level, bi0, sb0);
  assign fin2 = finish(fin1.next_ph, in_line_level, fin1.bit_idx, fin1.shift);

  // Tick update: count, close the phase and skip a following empty phase
  always_comb begin
    phase_nxt   = ph0;
    tick_nxt    = tc0;
    bit_nxt     = bi0;
    shift_nxt   = sb0;
    rd_byte_nxt = rd_byte_r;
    pres_nxt    = pres_r;
    release_nxt = 1'b1;
    busy_nxt    = 1'b0;
    done_nxt    = 1'b0;
    if (ph0 != PH_IDLE) begin
      busy_nxt = 1'b1;
      case (ph0)
        PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: release_nxt = 1'b0;
        PH_WR_SLOT:                       release_nxt = sb0[0];
        default:                          release_nxt = 1'b1;
      endcase
      tick_nxt = tc1;
      if (tc1 >= phase_len(ph0)) begin
        tick_nxt = '0;
        if (fin1.pres_load) pres_nxt = fin1.pres_val;
        if (fin1.rd_load) rd_byte_nxt = fin1.shift;
        if (fin1.next_ph != PH_IDLE && phase_len(fin1.next_ph) == '0) begin
          phase_nxt = fin2.next_ph;
          bit_nxt   = fin2.bit_idx;
          shift_nxt = fin2.shift;
          if (fin2.rd_load) rd_byte_nxt = fin2.shift;
        end else begin
          phase_nxt = fin1.next_ph;
          bit_nxt   = fin1.bit_idx;
          shift_nxt = fin1.shift;
        end
        done_nxt = (phase_nxt == PH_IDLE);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_low_r     <= RST_LOW_DEF;
      pres_sample_r <= PRES_SAMPLE_DEF;
      rst_tail_r    <= RST_TAIL_DEF;
      wr_low_r      <= WR_LOW_DEF;
      wr_slot_r     <= WR_SLOT_DEF;
      rd_low_r      <= RD_LOW_DEF;
      rd_sample_r   <= RD_SAMPLE_DEF;
      rd_rec_r      <= RD_REC_DEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RST_LOW:     rst_low_r     <= cfg_data;
        REG_PRES_SAMPLE: pres_sample_r <= cfg_data;
        REG_RST_TAIL:    rst_tail_r    <= cfg_data;
        REG_WR_LOW:      wr_low_r      <= cfg_data;
        REG_WR_SLOT:     wr_slot_r     <= cfg_data;
        REG_RD_LOW:      rd_low_r      <= cfg_data;
        REG_RD_SAMPLE:   rd_sample_r   <= cfg_data;
        REG_RD_REC:      rd_rec_r      <= cfg_data;
        default:         rd_rec_r      <= rd_rec_r;
      endcase
    end
  end

  // Engine state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      rd_byte_r <= '0;
      pres_r    <= 1'b0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      rd_byte_r <= rd_byte_nxt;
      pres_r    <= pres_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      release_r <= release_nxt;
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_release = release_r;
  assign out_busy_res     = busy_r;
  assign out_done_res     = done_r;
  assign out_read_data    = rd_byte_r;
  assign out_presence     = pres_r;

endmodule

// ===== rtl/owm_checker.sv =====
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks on the 1-Wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_line_release,
  input logic out_busy_res,
  input logic out_done_res
);

  // Input is held off only by a stalled result
  `OWM_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "in_stall without stalled result")

  // Every accepted tick offers a result on the next cycle
  `OWM_ASSERT_NXT(a_accept_out, clk, rst_n, in_valid && !in_stall, out_valid, "accepted tick gave no result")

  // A completing tick is part of a command
  `OWM_ASSERT_IMP(a_done_busy, clk, rst_n, out_valid && out_done_res, out_busy_res, "done without busy")

  // With no command running the bus is released
  `OWM_ASSERT_IMP(a_idle_release, clk, rst_n, out_valid && !out_busy_res, out_line_release, "idle bus driven low")

  // A stalled result stays offered
  `OWM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind one_wire_bus_master_core owm_checker u_owm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_line_release (out_line_release),
  .out_busy_res     (out_busy_res),
  .out_done_res     (out_done_res)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 1-Wire bus master timing engine.
// ----------------------------------------------------------------------------
// Ticks are pushed through the stall/valid input one at a time. A cycle
// accurate predictor of the slot engine works out the line drive, busy, done,
// read byte and presence for every accepted tick, and the result side compares
// each returned transaction against the oldest prediction. Directed tests cover
// the bus reset, byte write and byte read at short, all-zero and all-one
// timings, and commands the block must ignore. A random part then runs
// back-to-back resets and reads under several idling patterns and timings.
module tb;
  import owm_pkg::*;

  localparam int GAP_TICKS = 100;
  localparam int HOLD_LEN  = 80;
  localparam int LIMIT_NS  = 20_000_000;
  localparam int MAX_SHOWN = 40;

  typedef enum {LVL_RANDOM, LVL_LOW, LVL_HIGH} lvl_policy_t;

  typedef struct packed {
    logic       line_release;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       presence;
  } bus_result_t;

  // DUT connections
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 in_cmd_valid  = 1'b0;
  logic [1:0]           in_opcode     = OP_NONE;
  logic [7:0]           in_write_data = 8'h00;
  logic                 in_line_level = 1'b1;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 out_line_release;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [7:0]           out_read_data;
  logic                 out_presence;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_RST_LOW;
  logic [TICK_W-1:0]    cfg_data      = '0;

  // Predictor state
  logic [TICK_W-1:0]    slot_cfg [8];
  phase_t               bus_phase;
  logic [TICK_W-1:0]    tick_cnt;
  logic [2:0]           bit_idx;
  logic [7:0]           shreg;
  logic [7:0]           rd_byte;
  logic                 pres_flag;

  bus_result_t          result_q [$];

  // Pacing and bookkeeping
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int n_err          = 0;
  int n_checked      = 0;
  int n_ticks        = 0;
  int n_held         = 0;
  int n_cmds         = 0;
  int n_resets       = 0;
  int n_writes       = 0;
  int n_reads        = 0;

  one_wire_bus_master_core #(
    .BYTE_GAP_TICKS (GAP_TICKS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd_valid     (in_cmd_valid),
    .in_opcode        (in_opcode),
    .in_write_data    (in_write_data),
    .in_line_level    (in_line_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_release (out_line_release),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_presence     (out_presence),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // Slot engine predictor
  // ------------------------------------------------------------------

  // Registers that must be non-zero count a zero as one
  function automatic int floor1(input logic [TICK_W-1:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  function automatic int span_of(input phase_t ph);
    case (ph)
      PH_RST_LOW:  return floor1(slot_cfg[REG_RST_LOW]);
      PH_RST_WAIT: return floor1(slot_cfg[REG_PRES_SAMPLE]);
      PH_RST_TAIL: return int'(slot_cfg[REG_RST_TAIL]);
      PH_WR_LOW:   return floor1(slot_cfg[REG_WR_LOW]);
      PH_WR_SLOT:  return floor1(slot_cfg[REG_WR_SLOT]);
      PH_WR_GAP:   return GAP_TICKS;
      PH_RD_LOW:   return floor1(slot_cfg[REG_RD_LOW]);
      PH_RD_WAIT:  return floor1(slot_cfg[REG_RD_SAMPLE]);
      PH_RD_REC:   return int'(slot_cfg[REG_RD_REC]);
      default:     return 1;
    endcase
  endfunction

  function automatic logic drive_of(input phase_t ph);
    case (ph)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: return 1'b0;
      PH_WR_SLOT:                       return shreg[0];
      default:                          return 1'b1;
    endcase
  endfunction

  // Work done as a phase runs out; gives the phase that follows
  function automatic phase_t close_phase(input phase_t ph, input logic lvl);
    phase_t nxt;
    nxt = PH_IDLE;
    case (ph)
      PH_RST_LOW:  nxt = PH_RST_WAIT;
      PH_RST_WAIT: begin
        pres_flag = ~lvl;
        nxt = PH_RST_TAIL;
      end
      PH_WR_LOW:   nxt = PH_WR_SLOT;
      PH_WR_SLOT: begin
        shreg = shreg >> 1;
        if (int'(bit_idx) >= BITS_PER_BYTE - 1) begin
          bit_idx = '0;
          nxt = PH_WR_GAP;
        end else begin
          bit_idx = bit_idx + 1'b1;
          nxt = PH_WR_LOW;
        end
      end
      PH_RD_LOW:   nxt = PH_RD_WAIT;
      PH_RD_WAIT: begin
        shreg = {lvl, shreg[7:1]};
        nxt = PH_RD_REC;
      end
      PH_RD_REC: begin
        if (int'(bit_idx) >= BITS_PER_BYTE - 1) begin
          bit_idx = '0;
          rd_byte = shreg;
          nxt = PH_IDLE;
        end else begin
          bit_idx = bit_idx + 1'b1;
          nxt = PH_RD_LOW;
        end
      end
      default:     nxt = PH_IDLE;
    endcase
    return nxt;
  endfunction

  // One microsecond tick through the engine
  function automatic bus_result_t step_bus(input logic cmd, input logic [1:0] op,
                                           input logic [7:0] wdata, input logic lvl);
    bus_result_t r;
    r.line_release = 1'b1;
    r.busy         = 1'b0;
    r.done         = 1'b0;
    // a command is only taken up when idle; opcode three is not a command
    if (bus_phase == PH_IDLE && cmd && op != OP_NONE) begin
      tick_cnt = '0;
      bit_idx  = '0;
      n_cmds++;
      case (op)
        OP_RESET: begin
          bus_phase = PH_RST_LOW;
          shreg = 8'h00;
          n_resets++;
        end
        OP_WRITE: begin
          bus_phase = PH_WR_LOW;
          shreg = wdata;
          n_writes++;
        end
        default: begin
          bus_phase = PH_RD_LOW;
          shreg = 8'h00;
          n_reads++;
        end
      endcase
    end
    if (bus_phase != PH_IDLE) begin
      r.line_release = drive_of(bus_phase);
      r.busy = 1'b1;
      tick_cnt = tick_cnt + 1'b1;
      if (int'(tick_cnt) >= span_of(bus_phase)) begin
        bus_phase = close_phase(bus_phase, lvl);
        tick_cnt = '0;
        // zero-length tail, recovery or gap is skipped outright
        while (bus_phase != PH_IDLE && span_of(bus_phase) == 0)
          bus_phase = close_phase(bus_phase, lvl);
        if (bus_phase == PH_IDLE) r.done = 1'b1;
      end
    end
    r.read_data = rd_byte;
    r.presence  = pres_flag;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Result side: checking and stall generation
  // ------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      n_err++;
      if (n_err <= MAX_SHOWN) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  task automatic check_result;
    bus_result_t want;
    if (result_q.size() == 0) begin
      n_err++;
      if (n_err <= MAX_SHOWN) $error("result transaction with no tick waiting for it");
    end else begin
      want = result_q.pop_front();
      n_checked++;
      compare_field("line_release", 8'(want.line_release), 8'(out_line_release));
      compare_field("busy_res", 8'(want.busy), 8'(out_busy_res));
      compare_field("done_res", 8'(want.done), 8'(out_done_res));
      compare_field("read_data", want.read_data, out_read_data);
      compare_field("presence", 8'(want.presence), 8'(out_presence));
    end
  endtask

  // Check each result transaction as it is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // Long hold-offs are requested by bumping hold_reqs and counted out here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_left <= HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic set_pacing(input int src_pct, input int sink_pct);
    src_gap_pct    = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  function automatic logic pick_level(input lvl_policy_t pol);
    case (pol)
      LVL_LOW:  return 1'b0;
      LVL_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Offer one tick, hold it until taken, then predict its result
  task automatic send_tick(input logic cmd, input logic [1:0] op,
                           input logic [7:0] wdata, input logic lvl);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd_valid  <= cmd;
    in_opcode     <= op;
    in_write_data <= wdata;
    in_line_level <= lvl;
    @(posedge clk);
    while (in_stall) begin
      n_held++;
      @(posedge clk);
    end
    result_q.push_back(step_bus(cmd, op, wdata, lvl));
    n_ticks++;
  endtask

  // Issue a command and tick it through to completion; noise_pct of the busy
  // ticks also carry a command, which the engine must ignore
  task automatic run_command(input logic [1:0] op, input logic [7:0] wdata,
                             input lvl_policy_t pol, input int noise_pct);
    send_tick(1'b1, op, wdata, pick_level(pol));
    while (bus_phase != PH_IDLE)
      send_tick($urandom_range(0, 99) < noise_pct, 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)), pick_level(pol));
  endtask

  // Finish any command, drain every result and let the pipeline empty
  task automatic settle_bus;
    while (bus_phase != PH_IDLE)
      send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slot_cfg[idx] = val;
  endtask

  // Fixed: every register gets val. Scattered: mostly short counts, now and
  // then anything up to val.
  task automatic program_timing(input bit scatter, input logic [TICK_W-1:0] val);
    int i;
    settle_bus();
    for (i = REG_RST_LOW; i <= REG_RD_REC; i++) begin
      if (!scatter)
        write_reg(i[CFG_IDX_W-1:0], val);
      else if ($urandom_range(0, 7) == 0)
        write_reg(i[CFG_IDX_W-1:0], TICK_W'($urandom_range(0, val)));
      else
        write_reg(i[CFG_IDX_W-1:0], TICK_W'($urandom_range(0, 2)));
    end
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Idle ticks and opcode three leave the bus released and idle
  task automatic test_idle_ticks;
    send_tick(1'b0, OP_RESET, 8'h00, 1'b0);
    send_tick(1'b0, OP_READ, 8'hFF, 1'b1);
    send_tick(1'b1, OP_NONE, 8'hFF, 1'b0);
    send_tick(1'b1, OP_NONE, 8'h00, 1'b1);
  endtask

  // Reset pulse at the shortest timing, with and without a device answering
  task automatic test_bus_reset;
    program_timing(1'b0, 10'd1);
    run_command(OP_RESET, 8'h00, LVL_LOW, 0);
    run_command(OP_RESET, 8'h00, LVL_HIGH, 0);
  endtask

  task automatic test_byte_write;
    run_command(OP_WRITE, 8'h5A, LVL_RANDOM, 0);
  endtask

  task automatic test_byte_read;
    run_command(OP_READ, 8'h00, LVL_HIGH, 0);
    run_command(OP_READ, 8'hFF, LVL_LOW, 0);
  endtask

  // Every busy tick, completing tick included, carries another command
  task automatic test_busy_ignored;
    run_command(OP_READ, 8'h00, LVL_RANDOM, 100);
  endtask

  // All-zero counts (floors and skipped phases), then all ones
  task automatic test_timing_extremes;
    program_timing(1'b0, 10'h000);
    run_command(OP_RESET, 8'h00, LVL_HIGH, 0);
    run_command(OP_READ, 8'h00, LVL_RANDOM, 0);
    program_timing(1'b0, 10'h001);
    run_command(OP_RESET, 8'h00, LVL_LOW, 0);
    run_command(OP_READ, 8'h00, LVL_RANDOM, 0);
  endtask

  // Result side holds off while ticks keep coming, so the input backs up
  task automatic test_backpressure;
    set_pacing(0, 0);
    program_timing(1'b1, 10'd8);
    hold_reqs <= hold_reqs + 1;
    run_command(OP_READ, 8'h00, LVL_RANDOM, 0);
    hold_reqs <= hold_reqs + 1;
    run_command(OP_RESET, 8'h00, LVL_RANDOM, 0);
  endtask

  // Back-to-back resets and reads with random content under each idling pattern
  task automatic test_random_traffic;
    int pass_i;
    int goal;
    int k;
    for (pass_i = 0; pass_i < 4; pass_i++) begin
      case (pass_i)
        0:       set_pacing(0, 0);
        1:       set_pacing(61, 0);
        2:       set_pacing(0, 61);
        default: set_pacing(13, 13);
      endcase
      program_timing(1'b1, (pass_i == 0) ? 10'd40 : 10'd12);
      goal = n_ticks + 28;
      while (n_ticks < goal) begin
        // some idle ticks, a few carrying opcode three
        repeat ($urandom_range(0, 2)) begin
          k = $urandom_range(0, 3);
          if (k == 0)
            send_tick(1'b1, OP_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          else
            send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
        k = $urandom_range(0, 9);
        if (k < 4)
          run_command(OP_RESET, 8'h00, LVL_RANDOM, 8);
        else
          run_command(OP_READ, 8'h00, LVL_RANDOM, 8);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    slot_cfg[REG_RST_LOW]     = RST_LOW_DEF;
    slot_cfg[REG_PRES_SAMPLE] = PRES_SAMPLE_DEF;
    slot_cfg[REG_RST_TAIL]    = RST_TAIL_DEF;
    slot_cfg[REG_WR_LOW]      = WR_LOW_DEF;
    slot_cfg[REG_WR_SLOT]     = WR_SLOT_DEF;
    slot_cfg[REG_RD_LOW]      = RD_LOW_DEF;
    slot_cfg[REG_RD_SAMPLE]   = RD_SAMPLE_DEF;
    slot_cfg[REG_RD_REC]      = RD_REC_DEF;
    bus_phase = PH_IDLE;
    tick_cnt  = '0;
    bit_idx   = '0;
    shreg     = 8'h00;
    rd_byte   = 8'h00;
    pres_flag = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_bus_reset();
    test_byte_write();
    test_byte_read();
    test_busy_ignored();
    test_timing_extremes();
    test_backpressure();
    test_random_traffic();

    settle_bus();
    repeat (5) @(posedge clk);

    $display("Ran %0d bus resets, %0d byte writes and %0d byte reads over %0d ticks;",
             n_resets, n_writes, n_reads, n_ticks);
    $display("%0d results checked, input held off for %0d cycles, %0d mismatches.",
             n_checked, n_held, n_err);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/owm_pkg.sv
rtl/one_wire_bus_master_core.sv
rtl/owm_checker.sv
verif/tb.sv
